>>> sv/lebu_pkg.sv
// Package for the line edit buffer: character and limit widths, key codes,
// cell command struct and controller state codes. No dependencies.
`default_nettype none

package lebu_pkg;

    localparam int CHAR_W      = 21;
    localparam int LIMIT_W     = 7;
    localparam int REQ_W       = 3;
    localparam int CHAR_BYTES  = 24;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT    = 3'd0,
        REQ_LEFT      = 3'd1,
        REQ_RIGHT     = 3'd2,
        REQ_HOME      = 3'd3,
        REQ_END       = 3'd4,
        REQ_BACKSPACE = 3'd5,
        REQ_DELETE    = 3'd6,
        REQ_ENTER     = 3'd7
    } req_t;

    // Command broadcast to every cell; each cell compares its own index
    // against the shared position to pick its move.
    typedef struct packed {
        logic ins;   // open a gap at the position, load the new character there
        logic rem;   // close the gap at the position, pull from the right
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'b01,
        ST_DELIVER = 2'b10
    } state_t;

endpackage

`default_nettype wire

>>> sv/lebu_cell.sv
// One character cell of the line chain. Takes data from its left or right
// neighbor or the new character. Depends on lebu_pkg.
`default_nettype none

module lebu_cell #(
    parameter int IDX   = 0,
    parameter int POS_W = 7
) (
    input  wire logic                        aclk,
    input  wire lebu_pkg::cell_cmd_t         cmd,
    input  wire logic [POS_W-1:0]            pos,
    input  wire logic [lebu_pkg::CHAR_W-1:0] new_char,
    input  wire logic [lebu_pkg::CHAR_W-1:0] left_char,
    input  wire logic [lebu_pkg::CHAR_W-1:0] right_char,
    output logic      [lebu_pkg::CHAR_W-1:0] char_q
);
    import lebu_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;

    always_comb begin
        char_next = char_reg;
        if (cmd.ins) begin
            if (MY_POS > pos) begin
                char_next = left_char;
            end else if (MY_POS == pos) begin
                char_next = new_char;
            end
        end else if (cmd.rem) begin
            if (MY_POS >= pos) begin
                char_next = right_char;
            end
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
    end

    assign char_q = char_reg;

endmodule

`default_nettype wire

>>> sv/line_edit_buffer_unit.sv
// Line edit buffer: top level with the key handler, the cell chain and the
// output register. Depends on lebu_pkg and lebu_cell.
`default_nettype none

// A console-style editable line. Each input transfer is one classified key
// (s_tuser = key kind, s_tdata = character). The line lives in a chain of
// LINE_DEPTH cells; on an insert or delete every cell at or past the cursor
// steps one place right (insert) or left (delete) in the same cycle. Enter
// drops s_tready and drains the line out of cell 0, one character per cycle
// unless m_tready holds it back, as the chain shifts left. An enter gives
// max(1, n) output transfers, where n = min(length, out_limit). The line
// length is cleared when the enter is taken. An empty delivery (empty line or
// a zero limit) is a single transfer with m_tdata 0, m_tlast 1 and m_tuser 1.
// An insert into a full line is dropped. out_limit is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle;
// the block itself does not enforce this.
module line_edit_buffer_unit #(
    parameter int LINE_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: out_limit
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,
    // key input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [20:0] char_code, [23:21] zero
    input  wire logic [2:0]  s_tuser,   // [2:0] req_type
    // delivered line
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // [20:0] out_char, [23:21] zero
    output logic             m_tlast,
    output logic      [0:0]  m_tuser    // [0] empty_line
);
    import lebu_pkg::*;

    localparam int LEN_W = $clog2(LINE_DEPTH + 1);
    localparam int CMP_W = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;
    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(LINE_DEPTH);

    // ---------------- registers ----------------
    state_t              state_reg, state_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    cur_reg, cur_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;      // characters still to deliver
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   m_char_reg, m_char_next;
    logic                m_last_reg, m_last_next;
    logic                m_empty_reg, m_empty_next;

    // ---------------- cell chain ----------------
    cell_cmd_t           cmd;
    logic [LEN_W-1:0]    cmd_pos;
    logic [CHAR_W-1:0]   cell_q [LINE_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < LINE_DEPTH; gi++) begin : g_cell
            logic [CHAR_W-1:0] left_c;
            logic [CHAR_W-1:0] right_c;
            if (gi == 0) begin : g_first
                assign left_c = '0;
            end else begin : g_mid_l
                assign left_c = cell_q[gi-1];
            end
            if (gi == LINE_DEPTH - 1) begin : g_last
                assign right_c = cell_q[gi];
            end else begin : g_mid_r
                assign right_c = cell_q[gi+1];
            end
            lebu_cell #(
                .IDX   (gi),
                .POS_W (LEN_W)
            ) u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .pos        (cmd_pos),
                .new_char   (s_tdata[CHAR_W-1:0]),
                .left_char  (left_c),
                .right_char (right_c),
                .char_q     (cell_q[gi])
            );
        end
    endgenerate

    // ---------------- key handling and delivery ----------------
    logic              s_xfer;
    logic              out_free;
    logic [CMP_W-1:0]  len_ext, lim_ext, n_ext;
    req_t              req;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign req      = req_t'(s_tuser);

    // delivered count: min(length, limit); length never exceeds the depth
    assign len_ext = CMP_W'(len_reg);
    assign lim_ext = CMP_W'(limit_reg);
    assign n_ext   = (len_ext < lim_ext) ? len_ext : lim_ext;

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        cur_next     = cur_reg;
        rem_next     = rem_reg;
        cmd          = '0;
        cmd_pos      = cur_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_empty_next = m_empty_reg;

        // retire the held result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    case (req)
                        REQ_INSERT: begin
                            if (len_reg < DEPTH_L) begin
                                cmd.ins  = 1'b1;
                                cur_next = cur_reg + 1'b1;
                                len_next = len_reg + 1'b1;
                            end
                        end
                        REQ_LEFT: begin
                            if (cur_reg != '0) begin
                                cur_next = cur_reg - 1'b1;
                            end
                        end
                        REQ_RIGHT: begin
                            if (cur_reg < len_reg) begin
                                cur_next = cur_reg + 1'b1;
                            end
                        end
                        REQ_HOME: begin
                            cur_next = '0;
                        end
                        REQ_END: begin
                            cur_next = len_reg;
                        end
                        REQ_BACKSPACE: begin
                            // drop the character left of the cursor
                            if (cur_reg != '0) begin
                                cmd.rem  = 1'b1;
                                cmd_pos  = cur_reg - 1'b1;
                                cur_next = cur_reg - 1'b1;
                                len_next = len_reg - 1'b1;
                            end
                        end
                        REQ_DELETE: begin
                            if (cur_reg < len_reg) begin
                                cmd.rem  = 1'b1;
                                len_next = len_reg - 1'b1;
                            end
                        end
                        REQ_ENTER: begin
                            rem_next   = n_ext[LEN_W-1:0];
                            len_next   = '0;
                            cur_next   = '0;
                            state_next = ST_DELIVER;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DELIVER: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (rem_reg == '0) begin
                        // empty line marker
                        m_char_next  = '0;
                        m_last_next  = 1'b1;
                        m_empty_next = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        // take cell 0 and advance the chain one place left
                        m_char_next  = cell_q[0];
                        m_last_next  = (rem_reg == LEN_W'(1));
                        m_empty_next = 1'b0;
                        cmd.rem      = 1'b1;
                        cmd_pos      = '0;
                        rem_next     = rem_reg - 1'b1;
                        if (rem_reg == LEN_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            limit_reg   <= LIMIT_RESET;
            len_reg     <= '0;
            cur_reg     <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            cur_reg     <= cur_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // payload holds without reset
    always_ff @(posedge aclk) begin
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
        m_empty_reg <= m_empty_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(CHAR_BYTES - CHAR_W){1'b0}}, m_char_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_empty_reg;

    // ---------------- assertions ----------------
    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= len_reg)
        else $error("cursor past end of line");

    a_len_in_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= DEPTH_L)
        else $error("line length exceeds depth");

    a_enter_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && req == REQ_ENTER) |=> (state_reg == ST_DELIVER && len_reg == '0))
        else $error("enter did not start delivery");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_empty_reg) |-> (m_last_reg && m_char_reg == '0))
        else $error("empty-line transfer not marked last");

endmodule

`default_nettype wire
